/* design/assert_macros.svh */
// assertion macros used by the rtl file text_glyph_rasterizer.sv
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rstn, expr)

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)

`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* design/tgr_pkg.sv */
// types, constants and the 5x7 font rom of the text glyph rasteriser
// no dependencies
package tgr_pkg;

    localparam int GLYPH_ROWS   = 7;
    localparam int GLYPH_COLS   = 5;
    localparam int CELL_BITS    = GLYPH_ROWS * GLYPH_COLS;
    localparam int CELL_ADVANCE = 6;
    localparam int CURSOR_MAX   = 32767;

    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    // row r of the glyph, bit 4 is the leftmost column
    typedef logic [GLYPH_ROWS-1:0][GLYPH_COLS-1:0] tgr_glyph_t;

    // one character cell ready for scanning
    typedef struct packed {
        logic [CELL_BITS-1:0] mask;   // visible set pixels, bit = row*5 + col
        logic [15:0]          base;   // address of the cell's top left corner
        logic [7:0]           color;
    } tgr_cell_t;

    // one framebuffer write from the scanner
    typedef struct packed {
        logic        active;
        logic        last;
        logic [15:0] addr;
        logic [7:0]  color;
    } tgr_pixel_t;

    function automatic tgr_glyph_t pack7(input logic [4:0] r0, input logic [4:0] r1,
                                         input logic [4:0] r2, input logic [4:0] r3,
                                         input logic [4:0] r4, input logic [4:0] r5,
                                         input logic [4:0] r6);
        tgr_glyph_t g;
        g[0] = r0;
        g[1] = r1;
        g[2] = r2;
        g[3] = r3;
        g[4] = r4;
        g[5] = r5;
        g[6] = r6;
        return g;
    endfunction

    function automatic tgr_glyph_t glyph_lookup(input logic [7:0] code);
        logic [7:0] c;
        tgr_glyph_t g;
        c = code;
        if (code >= LOWER_A && code <= LOWER_Z) begin
            c = code - CASE_SHIFT;
        end
        unique case (c)
            8'h41: g = pack7(5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11); // A
            8'h42: g = pack7(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E); // B
            8'h43: g = pack7(5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E); // C
            8'h44: g = pack7(5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C); // D
            8'h45: g = pack7(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F); // E
            8'h46: g = pack7(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10); // F
            8'h47: g = pack7(5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E); // G
            8'h48: g = pack7(5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11); // H
            8'h49: g = pack7(5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F); // I
            8'h4B: g = pack7(5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11); // K
            8'h4C: g = pack7(5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F); // L
            8'h4D: g = pack7(5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11); // M
            8'h4E: g = pack7(5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11); // N
            8'h4F: g = pack7(5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E); // O
            8'h50: g = pack7(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10); // P
            8'h52: g = pack7(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11); // R
            8'h53: g = pack7(5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E); // S
            8'h54: g = pack7(5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04); // T
            8'h55: g = pack7(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E); // U
            8'h56: g = pack7(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04); // V
            8'h57: g = pack7(5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11); // W
            8'h58: g = pack7(5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11); // X
            8'h59: g = pack7(5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04); // Y
            8'h2D: g = pack7(5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00); // -
            8'h3A: g = pack7(5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00); // :
            8'h3D: g = pack7(5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00); // =
            8'h2B: g = pack7(5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00); // +
            8'h2E: g = pack7(5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06); // .
            8'h30: g = pack7(5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E); // 0
            8'h31: g = pack7(5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E); // 1
            8'h32: g = pack7(5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F); // 2
            8'h33: g = pack7(5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E); // 3
            8'h34: g = pack7(5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02); // 4
            8'h35: g = pack7(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E); // 5
            8'h36: g = pack7(5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E); // 6
            8'h37: g = pack7(5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08); // 7
            8'h38: g = pack7(5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E); // 8
            8'h39: g = pack7(5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E); // 9
            default: g = '0; // J, Q, Z, space and unknown codes draw nothing
        endcase
        return g;
    endfunction

endpackage

/* design/text_glyph_rasterizer.sv */
// text glyph rasteriser top level: cursor, input register, cell preparation, output register
// depends on tgr_pkg, tgr_pixel_scan and assert_macros.svh
//
//  channel  | ports                                              | direction
//  ---------+----------------------------------------------------+----------
//  s_ (in)  | s_valid s_ready s_char_code s_origin_x s_origin_y  | into block
//           | s_ink_color s_new_string                           |
//  m_ (out) | m_valid m_ready m_pixel_address m_pixel_color      | out of block
//           | m_last_pixel                                       |
//
// a character gives one framebuffer word per visible pixel (0 to 35);
// the pixel scanner sets the pace: one framebuffer word a cycle unless m_ready stalls
// the first pixel word goes through the input, scanner and output registers
// synchronous active-low reset clears the cursor and all valid flags
// a stalled m_ready holds the output register, then the scanner, then the input register
`include "assert_macros.svh"

module text_glyph_rasterizer #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_char_code,
    input  logic signed [10:0] s_origin_x,
    input  logic signed [10:0] s_origin_y,
    input  logic [7:0]         s_ink_color,
    input  logic               s_new_string,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_pixel_address,
    output logic [7:0]         m_pixel_color,
    output logic               m_last_pixel
);
    import tgr_pkg::*;

    // signed bounds of the screen for the clipping compares
    localparam logic signed [16:0] COL_LIMIT = 17'(SCREEN_WIDTH);
    localparam logic signed [11:0] ROW_LIMIT = 12'(SCREEN_HEIGHT);
    localparam logic [15:0]        ROW_PITCH = 16'(SCREEN_WIDTH);

    // horizontal cursor, two's complement
    logic signed [15:0] cursor_reg;
    logic signed [15:0] cursor_next;
    logic signed [15:0] cx_sel;
    logic signed [16:0] cursor_sum;

    // input register
    logic               in_valid_reg;
    logic [7:0]         in_code_reg;
    logic signed [15:0] in_cx_reg;
    logic signed [10:0] in_oy_reg;
    logic [7:0]         in_color_reg;

    // output register
    logic               out_valid_reg;
    logic [15:0]        out_addr_reg;
    logic [7:0]         out_color_reg;
    logic               out_last_reg;

    // cell preparation
    tgr_glyph_t                glyph;
    tgr_cell_t                 scan_cell;
    logic [GLYPH_COLS-1:0]     col_ok;
    logic [GLYPH_ROWS-1:0]     row_ok;
    logic signed [16:0]        px;
    logic signed [11:0]        py;

    // handshake glue
    tgr_pixel_t pixel;
    logic       s_accept;
    logic       out_free;
    logic       scan_emit;
    logic       scan_can_load;
    logic       scan_load;
    logic       in_take;

    // cursor: origin on a new string, else the running column; saturating advance
    assign s_accept   = s_valid && s_ready;
    assign cx_sel     = s_new_string ? 16'(s_origin_x) : cursor_reg;
    assign cursor_sum = 17'(cx_sel) + 17'(CELL_ADVANCE);

    always_comb begin
        cursor_next = cursor_reg;
        if (s_accept) begin
            if (cursor_sum > $signed(17'(CURSOR_MAX))) begin
                cursor_next = 16'(CURSOR_MAX);
            end else begin
                cursor_next = cursor_sum[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
        end else begin
            cursor_reg <= cursor_next;
        end
    end

    // input register takes a word whenever it is empty or draining this cycle
    assign s_ready = !in_valid_reg || in_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (in_take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_code_reg  <= s_char_code;
            in_cx_reg    <= cx_sel;
            in_oy_reg    <= s_origin_y;
            in_color_reg <= s_ink_color;
        end
    end

    // glyph lookup and clipping: a pixel is kept only where it lands on screen
    assign glyph = glyph_lookup(in_code_reg);

    always_comb begin
        px = '0;
        py = '0;
        for (int rx = 0; rx < GLYPH_COLS; rx++) begin
            px = 17'(in_cx_reg) + 17'(rx);
            col_ok[rx] = (px >= 17'sd0) && (px < COL_LIMIT);
        end
        for (int ry = 0; ry < GLYPH_ROWS; ry++) begin
            py = 12'(in_oy_reg) + 12'(ry);
            row_ok[ry] = (py >= 12'sd0) && (py < ROW_LIMIT);
        end
    end

    // top left address wraps modulo 65536 like the framebuffer offset
    always_comb begin
        for (int ry = 0; ry < GLYPH_ROWS; ry++) begin
            for (int rx = 0; rx < GLYPH_COLS; rx++) begin
                scan_cell.mask[ry*GLYPH_COLS + rx] =
                    glyph[ry][GLYPH_COLS-1-rx] & col_ok[rx] & row_ok[ry];
            end
        end
        scan_cell.base  = 16'(in_oy_reg) * ROW_PITCH + 16'(in_cx_reg);
        scan_cell.color = in_color_reg;
    end

    // a cell with nothing visible leaves the input register without loading the scanner
    assign out_free      = !out_valid_reg || m_ready;
    assign scan_emit     = pixel.active && out_free;
    assign scan_can_load = !pixel.active || (scan_emit && pixel.last);
    assign scan_load     = in_valid_reg && (|scan_cell.mask) && scan_can_load;
    assign in_take       = in_valid_reg && (!(|scan_cell.mask) || scan_can_load);

    tgr_pixel_scan #(
        .SCREEN_WIDTH(SCREEN_WIDTH)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (scan_load),
        .scan_cell (scan_cell),
        .advance   (scan_emit),
        .pixel     (pixel)
    );

    // output register parts the scanner from the downstream stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (scan_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_emit) begin
            out_addr_reg  <= pixel.addr;
            out_color_reg <= pixel.color;
            out_last_reg  <= pixel.last;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pixel_address = out_addr_reg;
    assign m_pixel_color   = out_color_reg;
    assign m_last_pixel    = out_last_reg;

    // a loaded cell always has at least one word to give
    `ASSERT_NEXT(a_load_busy, aclk, aresetn, scan_load, pixel.active)

    // plain advance of the cursor by one cell when far from saturation
    `ASSERT_NEXT(a_cursor_step, aclk, aresetn, s_accept && !s_new_string && (cursor_reg < 16'sd32761), cursor_reg == $past(cursor_reg) + 16'sd6)

    // no word appears unless the scanner had one
    `ASSERT_NEXT(a_no_phantom, aclk, aresetn, !out_valid_reg && !pixel.active, !out_valid_reg)

endmodule

/* design/tgr_pixel_scan.sv */
// pixel scanner: walks the visible pixel mask of one cell, one write a cycle while advance is high
// depends on tgr_pkg
module tgr_pixel_scan #(
    parameter int SCREEN_WIDTH = 320
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  tgr_pkg::tgr_cell_t scan_cell,
    input  logic              advance,
    output tgr_pkg::tgr_pixel_t pixel
);
    import tgr_pkg::*;

    logic [CELL_BITS-1:0] mask_reg;
    logic [CELL_BITS-1:0] mask_next;
    logic [15:0]          base_reg;
    logic [7:0]           color_reg;
    logic [CELL_BITS-1:0] low_bit;
    logic [CELL_BITS-1:0] rest;
    logic [15:0]          offset;

    // isolate the lowest set bit: row-major, top left first
    assign low_bit = mask_reg & (~mask_reg + CELL_BITS'(1));
    assign rest    = mask_reg & ~low_bit;

    always_comb begin
        offset = '0;
        for (int ry = 0; ry < GLYPH_ROWS; ry++) begin
            for (int rx = 0; rx < GLYPH_COLS; rx++) begin
                if (low_bit[ry*GLYPH_COLS + rx]) begin
                    offset = offset | 16'(ry * SCREEN_WIDTH + rx);
                end
            end
        end
    end

    always_comb begin
        mask_next = mask_reg;
        if (load) begin
            mask_next = scan_cell.mask;
        end else if (advance) begin
            mask_next = rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            base_reg  <= scan_cell.base;
            color_reg <= scan_cell.color;
        end
    end

    assign pixel.active = |mask_reg;
    assign pixel.last   = ~|rest;
    assign pixel.addr   = base_reg + offset;
    assign pixel.color  = color_reg;

endmodule
